/* rtl/lfpd_pkg.sv */
// Shared types, constants and functions for the PD line follower drive.
package lfpd_pkg;

   localparam int NUM_SENSORS = 8;
   localparam int SAMPLE_W    = 8;
   localparam int SCAN_W      = NUM_SENSORS * SAMPLE_W;
   localparam int ERR_W       = 5;
   localparam int DUTY_W      = 8;
   localparam int TERM_W      = 16;
   localparam int DRIVE_W     = TERM_W + 1;
   localparam int DUTY_MAX    = 255;
   localparam int RSP_W       = 32;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLDS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D     = 8'd3;

   localparam logic [CSR_DATA_W-1:0] THRESHOLDS_RESET = 64'h6464_6464_6464_6464;
   localparam logic [7:0]            BASE_SPEED_RESET = 8'd100;
   localparam logic [7:0]            GAIN_P_RESET     = 8'd6;
   localparam logic [7:0]            GAIN_D_RESET     = 8'd18;

   localparam logic [ERR_W-1:0] ERR_MOST_NEG = 5'b10000;

   typedef struct packed {
      logic                    hit;
      logic signed [ERR_W-1:0] err;
   } pattern_type;

   typedef struct packed {
      logic              rev;
      logic [DUTY_W-1:0] duty;
   } drive_type;

   function automatic pattern_type lfpd_pattern(input logic [NUM_SENSORS-1:0] mask);
      pattern_type p;
      p.hit = 1'b1;
      case (mask)
         8'h01:   p.err = 5'sd15;
         8'h02:   p.err = 5'sd10;
         8'h04:   p.err = 5'sd5;
         8'h08:   p.err = 5'sd1;
         8'h10:   p.err = -5'sd1;
         8'h20:   p.err = -5'sd5;
         8'h40:   p.err = -5'sd10;
         8'h80:   p.err = -5'sd15;
         8'h03:   p.err = 5'sd13;
         8'h06:   p.err = 5'sd7;
         8'h0C:   p.err = 5'sd3;
         8'h18:   p.err = 5'sd0;
         8'h30:   p.err = -5'sd3;
         8'h60:   p.err = -5'sd7;
         8'hC0:   p.err = -5'sd13;
         8'h07:   p.err = 5'sd10;
         8'h0E:   p.err = 5'sd5;
         8'h1C:   p.err = 5'sd1;
         8'h38:   p.err = -5'sd1;
         8'h70:   p.err = -5'sd5;
         8'hE0:   p.err = -5'sd10;
         default: begin
            p.hit = 1'b0;
            p.err = 5'sd0;
         end
      endcase
      return p;
   endfunction

   function automatic drive_type lfpd_drive(input logic signed [DRIVE_W-1:0] v);
      logic signed [DRIVE_W-1:0] lim;
      logic signed [DRIVE_W-1:0] sat;
      logic signed [DRIVE_W-1:0] mag;
      drive_type d;
      lim = DRIVE_W'(DUTY_MAX);
      if (v > lim) begin
         sat = lim;
      end else if (v < -lim) begin
         sat = -lim;
      end else begin
         sat = v;
      end
      d.rev  = sat[DRIVE_W-1];
      mag    = d.rev ? -sat : sat;
      d.duty = mag[DUTY_W-1:0];
      return d;
   endfunction

endpackage

/* rtl/line_follower_pd_drive_top.sv */
// PD line follower motor drive: sensor scan in, motor duty and direction out.
//
//  channel | direction | payload
//  req_    | in        | tdata[63:0] = sample_0 .. sample_7, one byte each
//  rsp_    | out       | tdata[31:0] = mask, error, right duty/rev, left duty/rev
//  csr_    | in        | index[7:0], data[63:0]; 0 thresholds, 1 base, 2 kp, 3 kd
//
// One item per cycle unless rsp_ stalls; a taken item passes the input register and then the
// result register before it appears on rsp_. The two registers lie around one compare, pattern
// lookup, PD multiply-add and saturation path.
// Reset (synchronous) clears the error history and loads the register defaults.
// A stalled result holds and backs up into the input register; req_tready drops while
// both hold an item and the result is stalled, and rises again in the cycle the result is taken.
module line_follower_pd_drive_top
   import lfpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SCAN_W-1:0]     req_tdata,   // sample_0 [7:0] .. sample_7 [63:56]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // sensor_mask [7:0], line_error [12:8],
                                              // right_duty [20:13], right_reverse [21],
                                              // left_duty [29:22], left_reverse [30], 0 [31]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [CSR_DATA_W-1:0]   thr_ff;
   logic [7:0]              base_ff;
   logic [7:0]              gain_p_ff;
   logic [7:0]              gain_d_ff;
   logic signed [ERR_W-1:0] last_err_ff;
   logic signed [ERR_W-1:0] last_err_in;

   logic [SCAN_W-1:0]       scan_ff;
   logic                    scan_valid_ff;
   logic                    scan_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff;
   logic [RSP_W-1:0]        rsp_data_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    advance;
   logic                    take;
   logic [NUM_SENSORS-1:0]  mask;
   pattern_type             pat;
   logic signed [ERR_W-1:0] err;
   logic signed [TERM_W-1:0] err_w;
   logic signed [TERM_W-1:0] diff_w;
   logic signed [TERM_W-1:0] kp_w;
   logic signed [TERM_W-1:0] kd_w;
   logic signed [TERM_W-1:0] mv;
   logic signed [DRIVE_W-1:0] base_w;
   logic signed [DRIVE_W-1:0] right_v;
   logic signed [DRIVE_W-1:0] left_v;
   drive_type               right_d;
   drive_type               left_d;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLDS_RESET;
         base_ff   <= BASE_SPEED_RESET;
         gain_p_ff <= GAIN_P_RESET;
         gain_d_ff <= GAIN_D_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLDS: thr_ff    <= csr_data;
            CSR_BASE_SPEED: base_ff   <= csr_data[7:0];
            CSR_GAIN_P:     gain_p_ff <= csr_data[7:0];
            CSR_GAIN_D:     gain_d_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign advance    = scan_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !scan_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
         mask[k] = scan_ff[k*SAMPLE_W +: SAMPLE_W] > thr_ff[k*SAMPLE_W +: SAMPLE_W];
      end
   end

   always_comb begin
      pat     = lfpd_pattern(mask);
      err     = pat.hit ? pat.err : last_err_ff;
      err_w   = TERM_W'(err);
      diff_w  = TERM_W'(err) - TERM_W'(last_err_ff);
      kp_w    = signed'(TERM_W'(gain_p_ff));
      kd_w    = signed'(TERM_W'(gain_d_ff));
      mv      = TERM_W'(kp_w * err_w) + TERM_W'(kd_w * diff_w);
      base_w  = signed'(DRIVE_W'(base_ff));
      right_v = base_w + DRIVE_W'(mv);
      left_v  = base_w - DRIVE_W'(mv);
      right_d = lfpd_drive(right_v);
      left_d  = lfpd_drive(left_v);
   end

   always_comb begin
      scan_valid_in = take || (scan_valid_ff && !advance);
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);
      last_err_in   = advance ? err : last_err_ff;
      rsp_data_in   = advance ? {1'b0, left_d.rev, left_d.duty, right_d.rev, right_d.duty,
                                 err, mask}
                              : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_err_ff   <= '0;
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_err_ff   <= last_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         scan_ff <= req_tdata;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/lfpd_checker.sv */
// Port-level checks for the PD line follower drive, bound to the top level.
module lfpd_checker
   import lfpd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   logic [ERR_W-1:0]  line_err;
   logic [DUTY_W-1:0] right_duty;
   logic              right_rev;
   logic [DUTY_W-1:0] left_duty;
   logic              left_rev;

   assign line_err   = rsp_tdata[12:8];
   assign right_duty = rsp_tdata[20:13];
   assign right_rev  = rsp_tdata[21];
   assign left_duty  = rsp_tdata[29:22];
   assign left_rev   = rsp_tdata[30];

   hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   error_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> line_err != ERR_MOST_NEG)
      else $error("line error out of range");

   reverse_has_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(right_rev && right_duty == '0) && !(left_rev && left_duty == '0))
      else $error("reverse flag with zero duty");

endmodule

bind line_follower_pd_drive_top lfpd_checker u_lfpd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
